// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/csem_pkg.sv
// Shared types and codes for the counting semaphore core.
// No dependencies; imported by the core and its port checker.
package csem_pkg;

  localparam int CNT_W  = 16;
  localparam int CFG_W  = 15;
  localparam int TASK_W = 4;
  localparam int TMO_W  = 16;

  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

  localparam logic [1:0] MODE_WAIT   = 2'd0;
  localparam logic [1:0] MODE_SIGNAL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_INIT   = 2'd3;

  localparam logic [2:0] KIND_PROCEED     = 3'd0;
  localparam logic [2:0] KIND_BLK_UNTIMED = 3'd1;
  localparam logic [2:0] KIND_BLK_TIMED   = 3'd2;
  localparam logic [2:0] KIND_RELEASED    = 3'd3;
  localparam logic [2:0] KIND_ACK         = 3'd4;
  localparam logic [2:0] KIND_FULL        = 3'd5;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TASK_W-1:0] task_req;
    logic [TMO_W-1:0]  timeout;
  } in_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [TASK_W-1:0]       released_task;
    logic signed [CNT_W-1:0] count;
    logic                    last;
  } out_t;

endpackage

// File: rtl/csem_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; holds the wait FIFO and the timed waiter list.
module csem_ram #(
  parameter int DW    = 4,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/counting_semaphore_timed_wait_core.sv
// Counting semaphore with FIFO and timed waiters, waiter lists held in two RAMs.
// Depends on csem_pkg and csem_ram.
//
//   Channel  Signals                      Transfer rule
//   input    start, busy, in_data         taken when start && !busy
//   result   out_valid, out_data          one-cycle strobe, always taken
//   config   cfg_valid, cfg_ready, cfg_data  written when cfg_valid && cfg_ready
//
// Wait, init and a signal that releases nobody give their result the cycle after
// start. A releasing signal passes through S_SIG for the FIFO RAM read. A tick on a
// nonempty list walks the timed list in S_TICK, one RAM entry read per cycle and each
// survivor written back, then closes in S_TEND, holding busy throughout; a tick on an
// empty list answers the cycle after start.
// Reset is synchronous and needs no clearing pass; the lists start empty.
// Results cannot be stalled, so the block never waits on its receiver.
module counting_semaphore_timed_wait_core #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  csem_pkg::in_t               in_data,
  output logic                        out_valid,
  output csem_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [csem_pkg::CFG_W-1:0]  cfg_data
);
  import csem_pkg::*;

  localparam int CAP = (MAX_TASKS < 16) ? MAX_TASKS : 16;
  localparam int TIW = $clog2(CAP);
  localparam int TLW = $clog2(CAP + 1);
  localparam int FIW = $clog2(MAX_TASKS);
  localparam int FLW = $clog2(MAX_TASKS + 1);
  localparam int TDW = TASK_W + TIME_BITS;
  localparam logic [32:0] TMAX = (33'd1 << TIME_BITS) - 33'd1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SIG  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_TEND = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIW-1:0]          fhead_r, fhead_nxt;
  logic [FLW-1:0]          ffill_r, ffill_nxt;
  logic [TIW-1:0]          tbase_r, tbase_nxt;
  logic [TLW-1:0]          tlen_r, tlen_nxt;
  logic [CFG_W-1:0]        init_r;
  logic [TIW-1:0]          ri_r, ri_nxt;
  logic [TLW-1:0]          wi_r, wi_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [TASK_W-1:0]       pend_task_r, pend_task_nxt;
  logic signed [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  logic              f_we, f_re;
  logic [FIW-1:0]    f_waddr, f_raddr;
  logic [TASK_W-1:0] f_wdata, f_rdata;
  logic              t_we, t_re;
  logic [TIW-1:0]    t_waddr, t_raddr;
  logic [TDW-1:0]    t_wdata, t_rdata;

  logic signed [CNT_W-1:0] cnt_dec, cnt_inc, cnt_init;
  logic [FIW+1:0]          ftail_sum;
  logic [FIW-1:0]          ftail, fhead_inc;
  logic [TIW-1:0]          tbase_dn;
  logic [TIME_BITS-1:0]    tmo_sat, left_dec;
  logic [TASK_W-1:0]       rd_task;
  logic [TIME_BITS-1:0]    rd_left;
  logic [TLW-1:0]          ri_inc;
  logic [32:0]             tmo_ext;

  // Position in the timed ring, counted from its base.
  function automatic logic [TIW-1:0] ring_pos(input logic [TIW-1:0] b,
                                              input logic [TIW-1:0] o);
    logic [TIW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= (TIW+1)'(CAP)) begin
      s = s - (TIW+1)'(CAP);
    end
    return s[TIW-1:0];
  endfunction

  csem_ram #(.DW(TASK_W), .DEPTH(MAX_TASKS)) u_fifo_ram (
    .clk     (clk),
    .wr_en   (f_we),
    .wr_addr (f_waddr),
    .wr_data (f_wdata),
    .rd_en   (f_re),
    .rd_addr (f_raddr),
    .rd_data (f_rdata)
  );

  csem_ram #(.DW(TDW), .DEPTH(CAP)) u_timed_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_en   (t_re),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  assign cnt_dec  = (cnt_r == CNT_MIN) ? cnt_r : cnt_r - 16'sd1;
  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 16'sd1;
  assign cnt_init = {1'b0, init_r};

  assign ftail_sum = (FIW+2)'(fhead_r) + (FIW+2)'(ffill_r);
  assign ftail     = (ftail_sum >= (FIW+2)'(MAX_TASKS)) ?
                     FIW'(ftail_sum - (FIW+2)'(MAX_TASKS)) : ftail_sum[FIW-1:0];
  assign fhead_inc = (fhead_r == FIW'(MAX_TASKS - 1)) ? '0 : fhead_r + FIW'(1);
  assign tbase_dn  = (tbase_r == '0) ? TIW'(CAP - 1) : tbase_r - TIW'(1);

  assign tmo_ext = 33'(in_data.timeout);
  assign tmo_sat = (tmo_ext > TMAX) ? TMAX[TIME_BITS-1:0] : tmo_ext[TIME_BITS-1:0];

  assign rd_task  = t_rdata[TDW-1 -: TASK_W];
  assign rd_left  = t_rdata[TIME_BITS-1:0];
  assign left_dec = (rd_left != '0) ? rd_left - TIME_BITS'(1) : rd_left;
  assign ri_inc   = TLW'(ri_r) + TLW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fhead_nxt     = fhead_r;
    ffill_nxt     = ffill_r;
    tbase_nxt     = tbase_r;
    tlen_nxt      = tlen_r;
    ri_nxt        = ri_r;
    wi_nxt        = wi_r;
    pend_v_nxt    = pend_v_r;
    pend_task_nxt = pend_task_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    f_we          = 1'b0;
    f_waddr       = ftail;
    f_wdata       = in_data.task_req;
    f_re          = 1'b0;
    f_raddr       = fhead_r;
    t_we          = 1'b0;
    t_waddr       = tbase_dn;
    t_wdata       = {in_data.task_req, tmo_sat};
    t_re          = 1'b0;
    t_raddr       = tbase_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.mode)
            MODE_WAIT: begin
              out_valid_nxt = 1'b1;
              out_nxt.last  = 1'b1;
              if (!cnt_dec[CNT_W-1]) begin
                cnt_nxt       = cnt_dec;
                out_nxt.kind  = KIND_PROCEED;
                out_nxt.count = cnt_dec;
              end else if (in_data.timeout == '0) begin
                if (ffill_r >= FLW'(MAX_TASKS)) begin
                  out_nxt.kind  = KIND_FULL;
                  out_nxt.count = cnt_r;
                end else begin
                  f_we          = 1'b1;
                  ffill_nxt     = ffill_r + FLW'(1);
                  cnt_nxt       = cnt_dec;
                  out_nxt.kind  = KIND_BLK_UNTIMED;
                  out_nxt.count = cnt_dec;
                end
              end else if (tlen_r >= TLW'(CAP)) begin
                out_nxt.kind  = KIND_FULL;
                out_nxt.count = cnt_r;
              end else begin
                // Newest waiter goes in front of the ring.
                t_we          = 1'b1;
                tbase_nxt     = tbase_dn;
                tlen_nxt      = tlen_r + TLW'(1);
                cnt_nxt       = cnt_dec;
                out_nxt.kind  = KIND_BLK_TIMED;
                out_nxt.count = cnt_dec;
              end
            end
            MODE_SIGNAL: begin
              cnt_nxt = cnt_inc;
              if ((cnt_inc[CNT_W-1] || cnt_inc == '0) && ffill_r != '0) begin
                f_re      = 1'b1;
                fhead_nxt = fhead_inc;
                ffill_nxt = ffill_r - FLW'(1);
                state_nxt = S_SIG;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt.kind  = KIND_ACK;
                out_nxt.count = cnt_inc;
                out_nxt.last  = 1'b1;
              end
            end
            MODE_TICK: begin
              if (tlen_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt.kind  = KIND_ACK;
                out_nxt.count = cnt_r;
                out_nxt.last  = 1'b1;
              end else begin
                t_re       = 1'b1;
                ri_nxt     = '0;
                wi_nxt     = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_TICK;
              end
            end
            MODE_INIT: begin
              cnt_nxt       = cnt_init;
              fhead_nxt     = '0;
              ffill_nxt     = '0;
              tlen_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_nxt.kind  = KIND_ACK;
              out_nxt.count = cnt_init;
              out_nxt.last  = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SIG: begin
        out_valid_nxt         = 1'b1;
        out_nxt.kind          = KIND_RELEASED;
        out_nxt.released_task = f_rdata;
        out_nxt.count         = cnt_r;
        out_nxt.last          = 1'b1;
        state_nxt             = S_IDLE;
      end
      S_TICK: begin
        // A release is held back one step so the final one can carry last.
        if (left_dec == '0) begin
          cnt_nxt = cnt_inc;
          if (pend_v_r) begin
            out_valid_nxt         = 1'b1;
            out_nxt.kind          = KIND_RELEASED;
            out_nxt.released_task = pend_task_r;
            out_nxt.count         = pend_cnt_r;
          end
          pend_v_nxt    = 1'b1;
          pend_task_nxt = rd_task;
          pend_cnt_nxt  = cnt_inc;
        end else begin
          // Survivors are compacted toward the base; the write never passes the read.
          t_we    = 1'b1;
          t_waddr = ring_pos(tbase_r, wi_r[TIW-1:0]);
          t_wdata = {rd_task, left_dec};
          wi_nxt  = wi_r + TLW'(1);
        end
        if (ri_inc < tlen_r) begin
          t_re    = 1'b1;
          t_raddr = ring_pos(tbase_r, ri_inc[TIW-1:0]);
          ri_nxt  = ri_inc[TIW-1:0];
        end else begin
          state_nxt = S_TEND;
        end
      end
      S_TEND: begin
        tlen_nxt      = wi_r;
        out_valid_nxt = 1'b1;
        out_nxt.last  = 1'b1;
        if (pend_v_r) begin
          out_nxt.kind          = KIND_RELEASED;
          out_nxt.released_task = pend_task_r;
          out_nxt.count         = pend_cnt_r;
        end else begin
          out_nxt.kind  = KIND_ACK;
          out_nxt.count = cnt_r;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fhead_r     <= '0;
      ffill_r     <= '0;
      tbase_r     <= '0;
      tlen_r      <= '0;
      init_r      <= '0;
      ri_r        <= '0;
      wi_r        <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fhead_r     <= fhead_nxt;
      ffill_r     <= ffill_nxt;
      tbase_r     <= tbase_nxt;
      tlen_r      <= tlen_nxt;
      ri_r        <= ri_nxt;
      wi_r        <= wi_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        init_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_task_r <= pend_task_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

// File: rtl/csem_checker.sv
// Port-level checks for the counting semaphore core, bound to the top level.
// Depends on csem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csem_port_sva (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input csem_pkg::in_t  in_data,
  input logic           out_valid,
  input csem_pkg::out_t out_data
);
  import csem_pkg::*;

  // More results of the same transaction follow, so the core must stay busy.
  `ASSERT_IMP(a_nonlast_busy, clk, rst_n, out_valid && !out_data.last, busy)

  `ASSERT_IMP(a_task_only_on_release, clk, rst_n,
              out_valid && out_data.kind != KIND_RELEASED, out_data.released_task == '0)

  // Wait and init answer with a single result in the very next cycle.
  `ASSERT_NXT(a_wait_init_quick, clk, rst_n,
              start && !busy && (in_data.mode == MODE_WAIT || in_data.mode == MODE_INIT),
              out_valid && out_data.last)

  `ASSERT_IMP(a_proceed_nonneg, clk, rst_n,
              out_valid && out_data.kind == KIND_PROCEED, !out_data.count[CNT_W-1])

endmodule

bind counting_semaphore_timed_wait_core csem_port_sva u_csem_port_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
